### rtl/core/btc_pkg.sv
// shared types and constants of the block transposition cipher
package btc_pkg;

  // default for the largest usable block, and the key layout
  localparam int KEY_MAX_DEF = 16;
  localparam int KEY_SLOTS   = 16;
  localparam int KEY_W       = 4;
  localparam int KEY_BITS    = KEY_SLOTS * KEY_W;

  // field widths
  localparam int CHAR_W    = 8;
  localparam int BS_W      = 5;
  localparam int CFG_IDX_W = 2;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BSIZE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY   = 2'd2;

  // register reset values
  localparam logic [BS_W-1:0]     BSIZE_RESET = 5'd1;
  localparam logic [KEY_BITS-1:0] KEY_RESET   = 64'hFEDC_BA98_7654_3210;

  // character codes
  localparam logic [CHAR_W-1:0] DASH_CHAR  = 8'h2D;
  localparam logic [CHAR_W-1:0] SPACE_CHAR = 8'h20;

  // sequencer states
  typedef enum logic [1:0] {
    ST_FILL,
    ST_PAD,
    ST_EMIT
  } btc_state_t;

  // controller to datapath commands
  typedef struct packed {
    logic take;          // store the accepted character, advance fill point
    logic pad_step;      // place a pad character at the sweep position
    logic idx_from_fill; // start the pad sweep at the new fill point
    logic idx_zero;      // restart the sweep at position zero
    logic emit_step;     // load the output register from the sweep position
    logic clear;         // refill the store with pad, fill point to zero
    logic cfg_wr;        // configuration beat taken
  } btc_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic blk_full;  // the character being taken completes the block
    logic idx_final; // sweep position is the last one of the block
    logic out_free;  // output register can take a beat this cycle
  } btc_sts_t;

endpackage

### rtl/core/btc_ctrl.sv
// sequencer of the block transposition cipher: fill, pad and emit phases
module btc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  input  logic              s_tlast,
  input  logic              cfg_valid,
  input  btc_pkg::btc_sts_t sts,
  output logic              s_tready,
  output logic              cfg_ready,
  output btc_pkg::btc_cmd_t cmd
);
  import btc_pkg::*;

  btc_state_t state;
  btc_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_FILL;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_FILL: begin
        if (s_tvalid) begin
          if (sts.blk_full) begin
            state_next = ST_EMIT;
          end else if (s_tlast) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (sts.idx_final) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts.out_free && sts.idx_final) begin
          state_next = ST_FILL;
        end
      end
      default: state_next = ST_FILL;
    endcase
  end

  // outputs and commands
  always_comb begin
    cmd       = '0;
    s_tready  = 1'b0;
    cfg_ready = 1'b0;
    unique case (state)
      ST_FILL: begin
        s_tready   = 1'b1;
        cfg_ready  = 1'b1;
        cmd.cfg_wr = cfg_valid;
        cmd.take   = s_tvalid;
        if (s_tvalid) begin
          if (sts.blk_full) begin
            cmd.idx_zero = 1'b1;
          end else if (s_tlast) begin
            cmd.idx_from_fill = 1'b1;
          end
        end
      end
      ST_PAD: begin
        cmd.pad_step = 1'b1;
        cmd.idx_zero = sts.idx_final;
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_step = 1'b1;
          cmd.clear     = sts.idx_final;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

### rtl/core/btc_datapath.sv
// block store, configuration registers, counters and output register
module btc_datapath #(
  parameter int KEY_MAX = btc_pkg::KEY_MAX_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  btc_pkg::btc_cmd_t                cmd,
  output btc_pkg::btc_sts_t                sts,
  input  logic [btc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [btc_pkg::KEY_BITS-1:0]     cfg_data,
  input  logic [btc_pkg::CHAR_W-1:0]       in_char,
  input  logic                             in_last,
  input  logic                             m_tready,
  output logic                             m_tvalid,
  output logic [btc_pkg::CHAR_W-1:0]       m_tdata,
  output logic                             m_tlast,
  output logic                             m_tuser
);
  import btc_pkg::*;

  localparam int DEPTH = (KEY_MAX < KEY_SLOTS) ? KEY_MAX : KEY_SLOTS;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  // key entry of a block position
  function automatic logic [KEY_W-1:0] key_at(input logic [KEY_BITS-1:0] key,
                                              input logic [KEY_W-1:0] pos);
    return key[pos * KEY_W +: KEY_W];
  endfunction

  // letters, digits and space pass, anything else becomes a dash
  function automatic logic [CHAR_W-1:0] enc_filter(input logic [CHAR_W-1:0] c);
    logic ok;
    ok = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
         (c >= 8'h30 && c <= 8'h39) || (c == SPACE_CHAR);
    return ok ? c : DASH_CHAR;
  endfunction

  logic                mode;
  logic [BS_W-1:0]     block_size;
  logic [KEY_BITS-1:0] key_order;
  logic [CHAR_W-1:0]   store [DEPTH];
  logic [CNT_W-1:0]    fill;
  logic [CNT_W-1:0]    idx;
  logic                last_flag;

  logic [CNT_W-1:0]  n;
  logic [CHAR_W-1:0] pad;
  logic [CNT_W-1:0]  fill_inc;
  logic [CNT_W-1:0]  idx_inc;
  logic [CNT_W-1:0]  place_pos;
  logic [CHAR_W-1:0] place_char;
  logic [KEY_W-1:0]  place_key;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [CHAR_W-1:0] wr_data;
  logic              cfg_hit;
  logic              do_clear;
  logic [CHAR_W-1:0] clr_pad;
  logic [KEY_W-1:0]  rd_key;
  logic [IDX_W-1:0]  rd_addr;
  logic [CHAR_W-1:0] rd_char;

  // effective block size, clamped to one .. store depth
  always_comb begin
    if (block_size == '0) begin
      n = CNT_W'(1);
    end else if (block_size > BS_W'(DEPTH)) begin
      n = CNT_W'(DEPTH);
    end else begin
      n = CNT_W'(block_size);
    end
  end

  assign pad      = mode ? SPACE_CHAR : DASH_CHAR;
  assign fill_inc = CNT_W'(fill + 1'b1);
  assign idx_inc  = CNT_W'(idx + 1'b1);

  // placement: scatter by key when encrypting, straight when decrypting
  assign place_pos  = cmd.take ? fill : idx;
  assign place_char = cmd.take ? in_char : pad;
  assign place_key  = key_at(key_order, KEY_W'(place_pos[IDX_W-1:0]));

  always_comb begin
    if (mode) begin
      wr_en   = cmd.take || cmd.pad_step;
      wr_addr = place_pos[IDX_W-1:0];
      wr_data = place_char;
    end else begin
      wr_en   = (cmd.take || cmd.pad_step) && (BS_W'(place_key) < BS_W'(n));
      wr_addr = place_key[IDX_W-1:0];
      wr_data = enc_filter(place_char);
    end
  end

  // any write to a known register discards the partial block
  assign cfg_hit  = cmd.cfg_wr && (cfg_index == CFG_MODE || cfg_index == CFG_BSIZE ||
                                   cfg_index == CFG_KEY);
  assign do_clear = cmd.clear || cfg_hit;
  assign clr_pad  = (cmd.cfg_wr && cfg_index == CFG_MODE) ?
                    (cfg_data[0] ? SPACE_CHAR : DASH_CHAR) : pad;

  // read side: gather by key when decrypting, dash shows as space
  assign rd_key  = key_at(key_order, KEY_W'(idx[IDX_W-1:0]));
  assign rd_addr = mode ? rd_key[IDX_W-1:0] : idx[IDX_W-1:0];

  always_comb begin
    if (mode && !(BS_W'(rd_key) < BS_W'(n))) begin
      rd_char = SPACE_CHAR;
    end else begin
      rd_char = store[rd_addr];
    end
    if (mode && rd_char == DASH_CHAR) begin
      rd_char = SPACE_CHAR;
    end
  end

  // status towards the sequencer
  assign sts.blk_full  = fill_inc >= n;
  assign sts.idx_final = idx_inc >= n;
  assign sts.out_free  = !m_tvalid || m_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= 1'b0;
      block_size <= BSIZE_RESET;
      key_order  <= KEY_RESET;
    end else if (cmd.cfg_wr) begin
      case (cfg_index)
        CFG_MODE:  mode       <= cfg_data[0];
        CFG_BSIZE: block_size <= cfg_data[BS_W-1:0];
        CFG_KEY:   key_order  <= cfg_data;
        default:   ;
      endcase
    end
  end

  // block store
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        store[i] <= DASH_CHAR;
      end
    end else if (do_clear) begin
      for (int i = 0; i < DEPTH; i++) begin
        store[i] <= clr_pad;
      end
    end else if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
  end

  // fill point, sweep position and message end flag
  always_ff @(posedge clk) begin
    if (rst || do_clear) begin
      fill <= '0;
    end else if (cmd.take) begin
      fill <= fill_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (cmd.idx_zero) begin
      idx <= '0;
    end else if (cmd.idx_from_fill) begin
      idx <= fill_inc;
    end else if (cmd.pad_step || cmd.emit_step) begin
      idx <= idx_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      last_flag <= in_last;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.emit_step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_step) begin
      m_tdata <= rd_char;
      m_tlast <= sts.idx_final;
      m_tuser <= last_flag && sts.idx_final;
    end
  end

endmodule

### rtl/core/block_transposition_cipher.sv
// top level of the block transposition cipher
//
// Characters enter on the s_ stream, one per beat, s_tlast closing a message.
// They collect into a block of block_size positions (clamped to one .. the
// store depth, at most 16); in encrypt mode each is scattered to its key
// position and filtered, in decrypt mode it is stored in place and gathered
// by key on the way out. A full block, or a short one closed by s_tlast and
// padded, leaves on the m_ stream as one beat per block position; m_tlast
// marks each block's last beat and m_tuser the last beat of the message.
// Each block is taken in, padded from the fill point when a message ends
// early, and read out through the output register; the single block store
// is first filled and then read out one position per cycle while the
// receiver does not stall, so no input is taken until the readout is done.
// Configuration is taken on the cfg_ channel only while filling; every write
// to a register discards a partial block. Reset loads mode encrypt, block
// size 1 and the identity key, and fills the store with dashes.
// When the receiver stalls the output register holds its beat and the
// readout waits; a new message can be taken while the final beat waits.
module block_transposition_cipher #(
  parameter int KEY_MAX = btc_pkg::KEY_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  // input stream
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [btc_pkg::CHAR_W-1:0]    s_tdata,   // [7:0] in_char
  input  logic                          s_tlast,   // msg_end
  // output stream
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [btc_pkg::CHAR_W-1:0]    m_tdata,   // [7:0] out_char
  output logic                          m_tlast,   // block_last
  output logic                          m_tuser,   // [0] msg_last
  // configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [btc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [btc_pkg::KEY_BITS-1:0]  cfg_data
);
  import btc_pkg::*;

  btc_cmd_t cmd;
  btc_sts_t sts;

  // sequencer
  btc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tlast   (s_tlast),
    .cfg_valid (cfg_valid),
    .sts       (sts),
    .s_tready  (s_tready),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  // store and output path
  btc_datapath #(
    .KEY_MAX (KEY_MAX)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_char   (s_tdata),
    .in_last   (s_tlast),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

  // input is never taken while the block is being read out
  a_no_take_during_emit: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && cmd.emit_step))
    else $error("input taken during block readout");

  // after the final beat of a block the sequencer is back to taking input
  a_back_to_fill: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit_step && sts.idx_final) |=> s_tready)
    else $error("sequencer did not return to fill after block");

  // a message end always closes the block, so input stops next cycle
  a_msg_end_closes: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tlast) |=> !s_tready)
    else $error("message end did not close the block");

  // a beat with the message flag is always the last of its block
  a_msg_last_is_block_last: assert property (@(posedge clk) disable iff (rst)
    cmd.emit_step |=> (!m_tuser || m_tlast))
    else $error("message end flag outside block end");

endmodule
